// ===== rtl/cmab_pkg.sv =====
// Shared types, constants and helpers of the colormap alpha-blend compositor.
package cmab_pkg;

	// Default geometry and table sizes
	localparam int FRAME_WIDTH_D   = 256;
	localparam int FRAME_HEIGHT_D  = 256;
	localparam int COLOR_ENTRIES_D = 256;
	localparam int ALPHA_ENTRIES_D = 256;

	// Q12 fixed point: 4096 is 1.0
	localparam logic [12:0] Q_ONE = 13'd4096;
	localparam logic [12:0] Q_HALF = 13'd2048;

	// Luminance weights in Q12
	localparam logic signed [12:0] LUM_R = 13'sd1266;
	localparam logic signed [12:0] LUM_G = 13'sd1888;
	localparam logic signed [12:0] LUM_B = 13'sd942;

	// Request codes
	localparam logic [2:0] REQ_BLEND    = 3'd0;
	localparam logic [2:0] REQ_FRAME_WR = 3'd1;
	localparam logic [2:0] REQ_FRAME_RD = 3'd2;
	localparam logic [2:0] REQ_COLOR_WR = 3'd3;
	localparam logic [2:0] REQ_ALPHA_WR = 3'd4;

	// Configuration register indexes
	localparam logic [2:0] CFG_WINDOW_MIN  = 3'd0;
	localparam logic [2:0] CFG_WINDOW_GAIN = 3'd1;
	localparam logic [2:0] CFG_ALPHA_MAP   = 3'd2;
	localparam logic [2:0] CFG_RGB_INPUT   = 3'd3;
	localparam logic [2:0] CFG_COLOR_LAST  = 3'd4;
	localparam logic [2:0] CFG_ALPHA_LAST  = 3'd5;

	typedef logic [12:0] chan_t;
	typedef chan_t [2:0] pix_t;

	// What the frame stage does with an item
	typedef enum logic [1:0] {
		K_NONE,
		K_WRITE,
		K_READ,
		K_BLEND
	} kind_t;

	typedef struct packed {
		logic signed [15:0] window_min;
		logic [31:0]        window_gain;
		logic               use_alpha_map;
		logic               rgb_input;
		logic [7:0]         color_last;
		logic [7:0]         alpha_last;
	} cfg_t;

	// Control of one item as it travels down the pipeline
	typedef struct packed {
		kind_t      kind;
		logic       skip;
		logic       tw_color;
		logic       tw_alpha;
		logic [7:0] eidx;
		logic [7:0] px_x;
		logic [7:0] px_y;
		chan_t      amap;
		pix_t       newpix;
	} ctl_t;

	// Saturate a 13-bit channel to 1.0
	function automatic chan_t sat_q(input logic [12:0] v);
		return (v > Q_ONE) ? Q_ONE : v;
	endfunction

	// Clamp a signed value to 0..1.0
	function automatic chan_t clamp_q(input logic signed [47:0] v);
		chan_t r;
		if (v < 48'sd0) begin
			r = '0;
		end else if (v > 48'sd4096) begin
			r = Q_ONE;
		end else begin
			r = v[12:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/cmab_ifs.sv =====
// Handshake channels of the compositor: input items, result items, config writes.
interface cmab_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         req_type;
	logic [7:0]         pixel_x;
	logic [7:0]         pixel_y;
	logic signed [15:0] sample_red;
	logic signed [15:0] sample_green;
	logic signed [15:0] sample_blue;
	logic signed [15:0] alpha_in;
	logic [3:0]         bad_mask;
	logic [7:0]         entry_index;
	logic [38:0]        entry_value;
	modport source (output valid, req_type, pixel_x, pixel_y, sample_red, sample_green,
		sample_blue, alpha_in, bad_mask, entry_index, entry_value, input ready);
	modport sink (input valid, req_type, pixel_x, pixel_y, sample_red, sample_green,
		sample_blue, alpha_in, bad_mask, entry_index, entry_value, output ready);
endinterface

interface cmab_out_if;
	logic        valid;
	logic        ready;
	logic        updated;
	logic [12:0] pixel_red;
	logic [12:0] pixel_green;
	logic [12:0] pixel_blue;
	modport source (output valid, updated, pixel_red, pixel_green, pixel_blue, input ready);
	modport sink (input valid, updated, pixel_red, pixel_green, pixel_blue, output ready);
endinterface

interface cmab_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/cmab_window.sv =====
// Window, luminance and table index pipeline (stages 1 to 5).
module cmab_window (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  cmab_pkg::cfg_t     cfg,
	input  logic               v_in,
	input  cmab_pkg::ctl_t     ctl_in,
	input  logic signed [15:0] smp_r,
	input  logic signed [15:0] smp_g,
	input  logic signed [15:0] smp_b,
	output logic               v_s5,
	output cmab_pkg::ctl_t     ctl_s5,
	output cmab_pkg::pix_t     c_s5,
	output logic [7:0]         cidx_s5,
	output logic [7:0]         aidx_s5
);

	logic               v_s1, v_s2, v_s3, v_s4;
	cmab_pkg::ctl_t     ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic signed [16:0] d_s1 [3];
	logic signed [33:0] raw_s2 [3];
	logic signed [46:0] lp_s3 [3];
	logic signed [33:0] raw0_s3;
	cmab_pkg::pix_t     c_s3, c_s4;
	cmab_pkg::chan_t    val_s4;

	logic signed [15:0] smp [3];
	logic signed [12:0] lum_w [3];
	logic signed [49:0] prod [3];
	logic signed [48:0] lsum;
	cmab_pkg::chan_t    vsel;
	logic [20:0]        cprod, aprod;

	assign smp[0] = smp_r;
	assign smp[1] = smp_g;
	assign smp[2] = smp_b;
	assign lum_w[0] = cmab_pkg::LUM_R;
	assign lum_w[1] = cmab_pkg::LUM_G;
	assign lum_w[2] = cmab_pkg::LUM_B;

	// Scale each channel by the gain
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			prod[k] = d_s1[k] * $signed({1'b0, cfg.window_gain});
		end
	end

	// Sum luminance and pick the value that indexes the tables
	always_comb begin
		lsum = 49'(lp_s3[0]) + 49'(lp_s3[1]) + 49'(lp_s3[2]);
		if (cfg.rgb_input) begin
			vsel = cmab_pkg::clamp_q(48'($signed(lsum[48:12])));
		end else begin
			vsel = cmab_pkg::clamp_q(48'(raw0_s3));
		end
	end

	assign cprod = cfg.color_last * val_s4;
	assign aprod = cfg.alpha_last * val_s4;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			for (int k = 0; k < 3; k++) begin
				d_s1[k]   <= {smp[k][15], smp[k]} - {cfg.window_min[15], cfg.window_min};
				raw_s2[k] <= prod[k][49:16];
				lp_s3[k]  <= raw_s2[k] * lum_w[k];
				c_s3[k]   <= cmab_pkg::clamp_q(48'(raw_s2[k]));
			end
			raw0_s3 <= raw_s2[0];
			c_s4    <= c_s3;
			val_s4  <= vsel;
			c_s5    <= c_s4;
			cidx_s5 <= cprod[19:12];
			aidx_s5 <= aprod[19:12];
		end
	end

endmodule

// ===== rtl/cmab_tables.sv =====
// Color and alpha lookup memories, one write and one registered read each.
module cmab_tables #(
	parameter int COLOR_ENTRIES = cmab_pkg::COLOR_ENTRIES_D,
	parameter int ALPHA_ENTRIES = cmab_pkg::ALPHA_ENTRIES_D,
	localparam int CIW = $clog2(COLOR_ENTRIES),
	localparam int AIW = $clog2(ALPHA_ENTRIES)
) (
	input  logic            clk,
	input  logic            en,
	input  logic            cwe,
	input  logic [CIW-1:0]  cwaddr,
	input  cmab_pkg::pix_t  cwdata,
	input  logic            awe,
	input  logic [AIW-1:0]  awaddr,
	input  cmab_pkg::chan_t awdata,
	input  logic [CIW-1:0]  craddr,
	input  logic [AIW-1:0]  araddr,
	output cmab_pkg::pix_t  crd,
	output cmab_pkg::chan_t ard
);

	cmab_pkg::pix_t  cmem [COLOR_ENTRIES];
	cmab_pkg::chan_t amem [ALPHA_ENTRIES];

	// Write on request, read while the pipeline advances
	always_ff @(posedge clk) begin
		if (cwe) begin
			cmem[cwaddr] <= cwdata;
		end
		if (awe) begin
			amem[awaddr] <= awdata;
		end
		if (en) begin
			crd <= cmem[craddr];
			ard <= amem[araddr];
		end
	end

endmodule

// ===== rtl/cmab_frame.sv =====
// Frame store with read-modify-write blend, forwarding and output register.
module cmab_frame #(
	parameter int FRAME_WIDTH  = cmab_pkg::FRAME_WIDTH_D,
	parameter int FRAME_HEIGHT = cmab_pkg::FRAME_HEIGHT_D,
	localparam int FAW = $clog2(FRAME_WIDTH * FRAME_HEIGHT)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  cmab_pkg::cfg_t  cfg,
	input  logic            v_s5,
	input  cmab_pkg::ctl_t  ctl_s5,
	input  logic [FAW-1:0]  addr_s5,
	input  cmab_pkg::pix_t  c_s5,
	input  cmab_pkg::pix_t  ctbl,
	input  cmab_pkg::chan_t atbl,
	output logic            out_valid,
	output logic            out_updated,
	output cmab_pkg::pix_t  out_pix
);

	cmab_pkg::pix_t  fmem [FRAME_WIDTH * FRAME_HEIGHT];
	cmab_pkg::pix_t  rd_q;

	logic            v_s6, v_s7;
	cmab_pkg::ctl_t  ctl_s6;
	logic [FAW-1:0]  addr_s6, addr_s7;
	cmab_pkg::pix_t  c_s6;
	cmab_pkg::kind_t kind_s7;
	logic            ok_s7;
	cmab_pkg::pix_t  old_s7, new_s7;
	logic [25:0]     p1_s7 [3];
	logic [25:0]     p2_s7 [3];

	logic            wb_v_q;
	logic [FAW-1:0]  wb_addr_q;
	cmab_pkg::pix_t  wb_data_q;

	logic            wr7, we, ok6;
	cmab_pkg::pix_t  res7, old6, col6;
	cmab_pkg::chan_t a6;
	logic [26:0]     sum7 [3];

	// Form the stage 7 result and decide the write
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sum7[k] = 27'(p1_s7[k]) + 27'(p2_s7[k]) + 27'(cmab_pkg::Q_HALF);
		end
		res7 = old_s7;
		case (kind_s7)
			cmab_pkg::K_WRITE: res7 = new_s7;
			cmab_pkg::K_NONE:  res7 = '0;
			default: begin
				if (ok_s7) begin
					for (int k = 0; k < 3; k++) begin
						res7[k] = sum7[k][24:12];
					end
				end
			end
		endcase
		wr7 = (kind_s7 == cmab_pkg::K_WRITE) || ok_s7;
		we  = en && v_s7 && wr7;
	end

	// Forward pending writes to the pixel just read
	always_comb begin
		if (v_s7 && wr7 && addr_s7 == addr_s6) begin
			old6 = res7;
		end else if (wb_v_q && wb_addr_q == addr_s6) begin
			old6 = wb_data_q;
		end else begin
			old6 = rd_q;
		end
	end

	// Pick alpha and color, decide the blend
	always_comb begin
		a6  = cfg.use_alpha_map ? ctl_s6.amap : atbl;
		ok6 = (ctl_s6.kind == cmab_pkg::K_BLEND) && !ctl_s6.skip && (a6 != '0);
		col6 = cfg.rgb_input ? c_s6 : ctbl;
	end

	// Frame memory port
	always_ff @(posedge clk) begin
		if (we) begin
			fmem[addr_s7] <= res7;
		end
		if (en) begin
			rd_q <= fmem[addr_s5];
		end
	end

	// Valid bits and write-back tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6      <= 1'b0;
			v_s7      <= 1'b0;
			out_valid <= 1'b0;
			wb_v_q    <= 1'b0;
		end else begin
			if (en) begin
				v_s6      <= v_s5;
				v_s7      <= v_s6;
				out_valid <= v_s7;
			end
			if (we) begin
				wb_v_q <= 1'b1;
			end
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (we) begin
			wb_addr_q <= addr_s7;
			wb_data_q <= res7;
		end
		if (en) begin
			ctl_s6  <= ctl_s5;
			addr_s6 <= addr_s5;
			c_s6    <= c_s5;
			addr_s7 <= addr_s6;
			kind_s7 <= ctl_s6.kind;
			ok_s7   <= ok6;
			old_s7  <= old6;
			new_s7  <= ctl_s6.newpix;
			for (int k = 0; k < 3; k++) begin
				p1_s7[k] <= (cmab_pkg::Q_ONE - a6) * old6[k];
				p2_s7[k] <= a6 * col6[k];
			end
			out_updated <= wr7;
			out_pix     <= res7;
		end
	end

endmodule

// ===== rtl/colormap_alpha_blend_compositor.sv =====
// Top level of the colormap alpha-blend compositor.
// Takes one item per clock while the output is not stalled and returns one result
// per item from the output register; the rate is set by the single frame memory
// port, whose read-modify-write overlaps through forwarding of the two most recent
// writes, so back-to-back items on the same pixel run at full rate. The whole pipeline
// holds while a result waits at the output. Frame store and tables start undefined
// and need no clearing pass; write them before reading. Configure only while idle.
module colormap_alpha_blend_compositor #(
	parameter int FRAME_WIDTH   = cmab_pkg::FRAME_WIDTH_D,
	parameter int FRAME_HEIGHT  = cmab_pkg::FRAME_HEIGHT_D,
	parameter int COLOR_ENTRIES = cmab_pkg::COLOR_ENTRIES_D,
	parameter int ALPHA_ENTRIES = cmab_pkg::ALPHA_ENTRIES_D
) (
	input logic         clk,
	input logic         arst_n,
	cmab_cfg_if.sink    cfg_ch,
	cmab_in_if.sink     in_ch,
	cmab_out_if.source  out_ch
);

	localparam int FAW = $clog2(FRAME_WIDTH * FRAME_HEIGHT);
	localparam int CIW = $clog2(COLOR_ENTRIES);
	localparam int AIW = $clog2(ALPHA_ENTRIES);

	cmab_pkg::cfg_t     cfg_q;
	logic               en, acc, in_range;
	logic signed [16:0] d0;
	cmab_pkg::ctl_t     ctl0, ctl_s5;
	logic               v_s5;
	cmab_pkg::pix_t     c_s5, ctbl, out_pix;
	cmab_pkg::chan_t    atbl;
	logic [7:0]         cidx_s5, aidx_s5;
	logic [FAW-1:0]     addr_s5;
	logic [CIW-1:0]     craddr;
	logic [AIW-1:0]     araddr;
	logic               cwe, awe, out_valid, out_updated;

	// Advance whenever the output register is free or being drained
	assign en  = !out_valid || out_ch.ready;
	assign acc = in_ch.valid && en;
	assign in_ch.ready  = en;
	assign cfg_ch.ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_min    <= '0;
			cfg_q.window_gain   <= 32'd65536;
			cfg_q.use_alpha_map <= 1'b0;
			cfg_q.rgb_input     <= 1'b0;
			cfg_q.color_last    <= 8'd255;
			cfg_q.alpha_last    <= 8'd255;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				cmab_pkg::CFG_WINDOW_MIN:  cfg_q.window_min    <= cfg_ch.data[15:0];
				cmab_pkg::CFG_WINDOW_GAIN: cfg_q.window_gain   <= cfg_ch.data;
				cmab_pkg::CFG_ALPHA_MAP:   cfg_q.use_alpha_map <= cfg_ch.data[0];
				cmab_pkg::CFG_RGB_INPUT:   cfg_q.rgb_input     <= cfg_ch.data[0];
				cmab_pkg::CFG_COLOR_LAST:  cfg_q.color_last    <= cfg_ch.data[7:0];
				cmab_pkg::CFG_ALPHA_LAST:  cfg_q.alpha_last    <= cfg_ch.data[7:0];
				default: ;
			endcase
		end
	end

	// Decode the accepted word
	always_comb begin
		d0 = {in_ch.sample_red[15], in_ch.sample_red}
			- {cfg_q.window_min[15], cfg_q.window_min};
		in_range = (32'(in_ch.pixel_x) < FRAME_WIDTH) && (32'(in_ch.pixel_y) < FRAME_HEIGHT);
		ctl0 = '0;
		ctl0.px_x = in_ch.pixel_x;
		ctl0.px_y = in_ch.pixel_y;
		ctl0.eidx = in_ch.entry_index;
		for (int k = 0; k < 3; k++) begin
			ctl0.newpix[k] = cmab_pkg::sat_q(in_ch.entry_value[13*k +: 13]);
		end
		ctl0.amap = (in_ch.alpha_in > 16'sd4096) ? cmab_pkg::Q_ONE : in_ch.alpha_in[12:0];
		ctl0.skip = cfg_q.rgb_input ? (in_ch.bad_mask[2:0] != 3'b000) : in_ch.bad_mask[0];
		if (cfg_q.use_alpha_map && (in_ch.bad_mask[3] || in_ch.alpha_in <= 16'sd0)) begin
			ctl0.skip = 1'b1;
		end
		if (!cfg_q.rgb_input && !cfg_q.use_alpha_map && d0 < 17'sd0) begin
			ctl0.skip = 1'b1;
		end
		case (in_ch.req_type)
			cmab_pkg::REQ_BLEND:    ctl0.kind = in_range ? cmab_pkg::K_BLEND : cmab_pkg::K_NONE;
			cmab_pkg::REQ_FRAME_WR: ctl0.kind = in_range ? cmab_pkg::K_WRITE : cmab_pkg::K_NONE;
			cmab_pkg::REQ_FRAME_RD: ctl0.kind = in_range ? cmab_pkg::K_READ : cmab_pkg::K_NONE;
			cmab_pkg::REQ_COLOR_WR: ctl0.tw_color = 32'(in_ch.entry_index) < COLOR_ENTRIES;
			cmab_pkg::REQ_ALPHA_WR: ctl0.tw_alpha = 32'(in_ch.entry_index) < ALPHA_ENTRIES;
			default: ctl0.kind = cmab_pkg::K_NONE;
		endcase
	end

	cmab_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.cfg     (cfg_q),
		.v_in    (acc),
		.ctl_in  (ctl0),
		.smp_r   (in_ch.sample_red),
		.smp_g   (in_ch.sample_green),
		.smp_b   (in_ch.sample_blue),
		.v_s5    (v_s5),
		.ctl_s5  (ctl_s5),
		.c_s5    (c_s5),
		.cidx_s5 (cidx_s5),
		.aidx_s5 (aidx_s5)
	);

	// Saturate table indexes and form the frame address
	always_comb begin
		craddr = (32'(cidx_s5) >= COLOR_ENTRIES) ? CIW'(COLOR_ENTRIES - 1) : CIW'(cidx_s5);
		araddr = (32'(aidx_s5) >= ALPHA_ENTRIES) ? AIW'(ALPHA_ENTRIES - 1) : AIW'(aidx_s5);
		addr_s5 = FAW'(32'(ctl_s5.px_y) * FRAME_WIDTH + 32'(ctl_s5.px_x));
		cwe = en && v_s5 && ctl_s5.tw_color;
		awe = en && v_s5 && ctl_s5.tw_alpha;
	end

	cmab_tables #(
		.COLOR_ENTRIES (COLOR_ENTRIES),
		.ALPHA_ENTRIES (ALPHA_ENTRIES)
	) u_tables (
		.clk    (clk),
		.en     (en),
		.cwe    (cwe),
		.cwaddr (CIW'(ctl_s5.eidx)),
		.cwdata (ctl_s5.newpix),
		.awe    (awe),
		.awaddr (AIW'(ctl_s5.eidx)),
		.awdata (ctl_s5.newpix[0]),
		.craddr (craddr),
		.araddr (araddr),
		.crd    (ctbl),
		.ard    (atbl)
	);

	cmab_frame #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT)
	) u_frame (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.cfg         (cfg_q),
		.v_s5        (v_s5),
		.ctl_s5      (ctl_s5),
		.addr_s5     (addr_s5),
		.c_s5        (c_s5),
		.ctbl        (ctbl),
		.atbl        (atbl),
		.out_valid   (out_valid),
		.out_updated (out_updated),
		.out_pix     (out_pix)
	);

	assign out_ch.valid       = out_valid;
	assign out_ch.updated     = out_updated;
	assign out_ch.pixel_red   = out_pix[0];
	assign out_ch.pixel_green = out_pix[1];
	assign out_ch.pixel_blue  = out_pix[2];

endmodule
